>>> rtl/timeline_gap_overlap_checker_core_defines.svh
// Assertion macros used by the port-level assertion checker of the timeline checker.
`ifndef TIMELINE_GAP_OVERLAP_CHECKER_CORE_DEFINES_SVH
`define TIMELINE_GAP_OVERLAP_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TGOC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tgoc assertion failed");

// Next-cycle implication, disabled during reset.
`define TGOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tgoc assertion failed");

`endif

>>> rtl/tgoc_pkg.sv
// Shared types and constants for the timeline gap/overlap checker.
package tgoc_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_OFFSET = 2'd1;

   localparam logic [15:0] COUNTER_MAX = 16'hFFFF;

   // Raw timeline entry as taken from the request channel
   typedef struct packed {
      logic        restart;
      logic        has_time;
      logic [63:0] start_time;
      logic [31:0] seg_duration;
      logic [31:0] repeat_count;
   } entry_type;

   // Entry with its total span, duration * (repeat + 1), already formed
   typedef struct packed {
      logic        restart;
      logic        has_time;
      logic [63:0] start_time;
      logic [63:0] span;
   } timed_type;

   // Configuration register contents
   typedef struct packed {
      logic [31:0] tolerance;
      logic [63:0] time_offset;
   } cfg_type;

   // One result transaction
   typedef struct packed {
      logic        gap_seen;
      logic        overlap_seen;
      logic [63:0] entry_start;
      logic [63:0] next_cursor;
      logic [15:0] gaps_total;
      logic [15:0] overlaps_total;
      logic [63:0] largest_gap;
      logic [63:0] largest_overlap;
      logic [63:0] first_gap_pos;
      logic [63:0] first_overlap_pos;
   } result_type;

endpackage

>>> rtl/tgoc_span.sv
// Input register and span multiply stage: forms duration * (repeat + 1).
module tgoc_span (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tgoc_pkg::entry_type in_entry,
   output logic                out_valid,
   input  logic                out_ready,
   output tgoc_pkg::timed_type out_entry
);

   logic                s1_valid_ff;
   tgoc_pkg::entry_type s1_entry_ff;
   logic                s2_valid_ff;
   tgoc_pkg::timed_type s2_entry_ff;
   logic                s1_ready;
   logic                s2_ready;
   logic [32:0]         reps_in;
   logic [64:0]         product_in;
   tgoc_pkg::timed_type s2_entry_in;

   // Per-stage ready: a stage loads when empty or when it drains this cycle
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Span multiply, 32 x 33 bits; the product always fits in 64 bits
   always_comb begin
      reps_in                 = {1'b0, s1_entry_ff.repeat_count} + 33'd1;
      product_in              = {33'd0, s1_entry_ff.seg_duration} * {32'd0, reps_in};
      s2_entry_in.restart     = s1_entry_ff.restart;
      s2_entry_in.has_time    = s1_entry_ff.has_time;
      s2_entry_in.start_time  = s1_entry_ff.start_time;
      s2_entry_in.span        = product_in[63:0];
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) s1_entry_ff <= in_entry;
      if (s2_ready && s1_valid_ff) s2_entry_ff <= s2_entry_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_entry = s2_entry_ff;

endmodule

>>> rtl/tgoc_track.sv
// Cursor and statistics tracker with the result register.
module tgoc_track (
   input  logic                 clock,
   input  logic                 reset,
   input  tgoc_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tgoc_pkg::timed_type  in_entry,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tgoc_pkg::result_type out_result
);

   logic                 rsp_valid_ff;
   tgoc_pkg::result_type rsp_result_ff;
   tgoc_pkg::result_type rsp_result_in;

   logic [63:0] cursor_ff,    cursor_in;
   logic [15:0] gap_cnt_ff,   gap_cnt_in;
   logic [15:0] ovl_cnt_ff,   ovl_cnt_in;
   logic [63:0] worst_gap_ff, worst_gap_in;
   logic [63:0] worst_ovl_ff, worst_ovl_in;
   logic [63:0] gap_pos_ff,   gap_pos_in;
   logic [63:0] ovl_pos_ff,   ovl_pos_in;

   logic [63:0] cursor_base;
   logic [15:0] gap_cnt_base;
   logic [15:0] ovl_cnt_base;
   logic [63:0] worst_gap_base;
   logic [63:0] worst_ovl_base;
   logic [63:0] gap_pos_base;
   logic [63:0] ovl_pos_base;
   logic [63:0] start;
   logic [63:0] fwd_dist;
   logic [63:0] back_dist;
   logic [63:0] tol_wide;
   logic        is_gap;
   logic        is_ovl;
   logic        fire;

   assign in_ready = !rsp_valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   // Restart reloads the cursor and clears statistics ahead of the entry
   always_comb begin
      cursor_base    = in_entry.restart ? cfg.time_offset : cursor_ff;
      gap_cnt_base   = in_entry.restart ? 16'd0 : gap_cnt_ff;
      ovl_cnt_base   = in_entry.restart ? 16'd0 : ovl_cnt_ff;
      worst_gap_base = in_entry.restart ? 64'd0 : worst_gap_ff;
      worst_ovl_base = in_entry.restart ? 64'd0 : worst_ovl_ff;
      gap_pos_base   = in_entry.restart ? 64'd0 : gap_pos_ff;
      ovl_pos_base   = in_entry.restart ? 64'd0 : ovl_pos_ff;
   end

   // Gap / overlap classification against the cursor
   always_comb begin
      start     = in_entry.has_time ? in_entry.start_time : cursor_base;
      fwd_dist  = start - cursor_base;
      back_dist = cursor_base - start;
      tol_wide  = {32'd0, cfg.tolerance};
      is_gap    = in_entry.has_time && (start > cursor_base) && (fwd_dist > tol_wide);
      is_ovl    = in_entry.has_time && !is_gap && (cursor_base > start)
                  && (back_dist > tol_wide);
   end

   // Statistics and cursor update
   always_comb begin
      gap_cnt_in   = gap_cnt_base;
      ovl_cnt_in   = ovl_cnt_base;
      worst_gap_in = worst_gap_base;
      worst_ovl_in = worst_ovl_base;
      gap_pos_in   = gap_pos_base;
      ovl_pos_in   = ovl_pos_base;
      if (is_gap) begin
         if (gap_cnt_base == 16'd0) gap_pos_in = cursor_base;
         if (gap_cnt_base != tgoc_pkg::COUNTER_MAX) gap_cnt_in = gap_cnt_base + 16'd1;
         if (fwd_dist > worst_gap_base) worst_gap_in = fwd_dist;
      end
      if (is_ovl) begin
         if (ovl_cnt_base == 16'd0) ovl_pos_in = start;
         if (ovl_cnt_base != tgoc_pkg::COUNTER_MAX) ovl_cnt_in = ovl_cnt_base + 16'd1;
         if (back_dist > worst_ovl_base) worst_ovl_in = back_dist;
      end
      cursor_in = start + in_entry.span;
   end

   // Result transaction contents
   always_comb begin
      rsp_result_in.gap_seen          = is_gap;
      rsp_result_in.overlap_seen      = is_ovl;
      rsp_result_in.entry_start       = start;
      rsp_result_in.next_cursor       = cursor_in;
      rsp_result_in.gaps_total        = gap_cnt_in;
      rsp_result_in.overlaps_total    = ovl_cnt_in;
      rsp_result_in.largest_gap       = worst_gap_in;
      rsp_result_in.largest_overlap   = worst_ovl_in;
      rsp_result_in.first_gap_pos     = gap_pos_in;
      rsp_result_in.first_overlap_pos = ovl_pos_in;
   end

   // Tracker state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= 64'd0;
         gap_cnt_ff   <= 16'd0;
         ovl_cnt_ff   <= 16'd0;
         worst_gap_ff <= 64'd0;
         worst_ovl_ff <= 64'd0;
         gap_pos_ff   <= 64'd0;
         ovl_pos_ff   <= 64'd0;
      end else begin
         if (in_ready) rsp_valid_ff <= in_valid;
         if (fire) begin
            cursor_ff    <= cursor_in;
            gap_cnt_ff   <= gap_cnt_in;
            ovl_cnt_ff   <= ovl_cnt_in;
            worst_gap_ff <= worst_gap_in;
            worst_ovl_ff <= worst_ovl_in;
            gap_pos_ff   <= gap_pos_in;
            ovl_pos_ff   <= ovl_pos_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (fire) rsp_result_ff <= rsp_result_in;
   end

   assign out_valid  = rsp_valid_ff;
   assign out_result = rsp_result_ff;

endmodule

>>> rtl/timeline_gap_overlap_checker_core.sv
// Top level of the timeline gap/overlap checker: CSRs, span stage, tracker.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  restart, has_time, start_time, duration, repeats
//   rsp      out        rsp_valid / rsp_ready  flags, start, cursor, statistics
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_ready stays high; a result passes
// the input register, the span multiply register and the result register before
// it shows on rsp. The cursor update loop closes within the tracker. Reset
// clears all valids, the cursor, the statistics and both CSRs. A stalled result
// holds in the result register while the two upstream stages keep accepting
// until full.
module timeline_gap_overlap_checker_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tgoc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                      csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_restart,
   input  logic                             req_has_time,
   input  logic [63:0]                      req_start_time,
   input  logic [31:0]                      req_seg_duration,
   input  logic [31:0]                      req_repeat_count,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_gap_seen,
   output logic                             rsp_overlap_seen,
   output logic [63:0]                      rsp_entry_start,
   output logic [63:0]                      rsp_next_cursor,
   output logic [15:0]                      rsp_gaps_total,
   output logic [15:0]                      rsp_overlaps_total,
   output logic [63:0]                      rsp_largest_gap,
   output logic [63:0]                      rsp_largest_overlap,
   output logic [63:0]                      rsp_first_gap_pos,
   output logic [63:0]                      rsp_first_overlap_pos
);

   tgoc_pkg::cfg_type    cfg_ff;
   tgoc_pkg::entry_type  req_entry;
   tgoc_pkg::timed_type  timed_entry;
   tgoc_pkg::result_type result;
   logic                 timed_valid;
   logic                 timed_ready;

   // CSR write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance   <= 32'd0;
         cfg_ff.time_offset <= 64'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            tgoc_pkg::CSR_TOLERANCE:   cfg_ff.tolerance   <= csr_wdata[31:0];
            tgoc_pkg::CSR_TIME_OFFSET: cfg_ff.time_offset <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request fields gathered into one entry
   always_comb begin
      req_entry.restart      = req_restart;
      req_entry.has_time     = req_has_time;
      req_entry.start_time   = req_start_time;
      req_entry.seg_duration = req_seg_duration;
      req_entry.repeat_count = req_repeat_count;
   end

   tgoc_span u_span (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_entry  (req_entry),
      .out_valid (timed_valid),
      .out_ready (timed_ready),
      .out_entry (timed_entry)
   );

   tgoc_track u_track (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (timed_valid),
      .in_ready   (timed_ready),
      .in_entry   (timed_entry),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   // Result fields out to ports
   assign rsp_gap_seen          = result.gap_seen;
   assign rsp_overlap_seen      = result.overlap_seen;
   assign rsp_entry_start       = result.entry_start;
   assign rsp_next_cursor       = result.next_cursor;
   assign rsp_gaps_total        = result.gaps_total;
   assign rsp_overlaps_total    = result.overlaps_total;
   assign rsp_largest_gap       = result.largest_gap;
   assign rsp_largest_overlap   = result.largest_overlap;
   assign rsp_first_gap_pos     = result.first_gap_pos;
   assign rsp_first_overlap_pos = result.first_overlap_pos;

endmodule

>>> rtl/tgoc_checker.sv
// Port-level assertion checker for the timeline checker top, with its bind.
`include "timeline_gap_overlap_checker_core_defines.svh"

module tgoc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_gap_seen,
   input logic        rsp_overlap_seen,
   input logic [63:0] rsp_entry_start,
   input logic [15:0] rsp_gaps_total,
   input logic [15:0] rsp_overlaps_total,
   input logic [63:0] rsp_largest_gap
);

   // Stalled result transaction stays valid and holds its entry start
   `TGOC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_start))

   // A reported gap is reflected in the gap count
   `TGOC_ASSERT_IMPL(a_gap_counted, clock, reset, rsp_valid && rsp_gap_seen, rsp_gaps_total != 16'd0)

   // A reported overlap is reflected in the overlap count
   `TGOC_ASSERT_IMPL(a_ovl_counted, clock, reset, rsp_valid && rsp_overlap_seen, rsp_overlaps_total != 16'd0)

   // A gap is strictly beyond tolerance, so the largest gap is nonzero
   `TGOC_ASSERT_IMPL(a_gap_size, clock, reset, rsp_valid && rsp_gap_seen, rsp_largest_gap != 64'd0)

endmodule

bind timeline_gap_overlap_checker_core tgoc_checker u_tgoc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_gap_seen       (rsp_gap_seen),
   .rsp_overlap_seen   (rsp_overlap_seen),
   .rsp_entry_start    (rsp_entry_start),
   .rsp_gaps_total     (rsp_gaps_total),
   .rsp_overlaps_total (rsp_overlaps_total),
   .rsp_largest_gap    (rsp_largest_gap)
);
